@@ sv/qls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quicksort sorter package
// Sequencer state encoding used by the sorter unit.
// ----------------------------------------------------------------------------
package qls_pkg;

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        ST_LOAD     = 10'b00_0000_0001,
        ST_POP      = 10'b00_0000_0010,
        ST_PIVOT    = 10'b00_0000_0100,
        ST_READ     = 10'b00_0000_1000,
        ST_CMP      = 10'b00_0001_0000,
        ST_SWAP     = 10'b00_0010_0000,
        ST_PUSH     = 10'b00_0100_0000,
        ST_OUT_RD   = 10'b00_1000_0000,
        ST_OUT_LD   = 10'b01_0000_0000,
        ST_OUT_WAIT = 10'b10_0000_0000
    } qls_state_t;

endpackage

@@ sv/quicksort_lomuto_sorter_unit.sv @@
`timescale 1ns / 1ps
// Operation: each input item is stored as it is accepted. The item marked last starts an
// in-place quicksort: each partition pops a range and reads its pivot, then scans its
// elements in turn, swapping where needed, until the range stack is found empty; then
// each result is read from the store and held until the output takes it.
// Sets are handled one at a time; the block accepts no item while sorting or emitting.
// Reset (aresetn, synchronous, active low) empties the set and the range stack.
// ----------------------------------------------------------------------------
// Quicksort sorter, Lomuto partition
// Collects signed 64-bit items, sorts them in a RAM with one shared comparator
// under a small sequencer, and emits them in ascending order.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter_unit
    import qls_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [63:0] s_value,
    input  logic               s_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_sorted_value,
    output logic               m_end_of_set
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Sequencer and index registers.
    qls_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] bnd_reg, bnd_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;

    // Data-path registers (no reset needed, except m_valid_reg).
    logic [63:0] pivot_reg, pivot_next;
    logic [63:0] swap_reg, swap_next;
    logic [63:0] m_value_reg, m_value_next;
    logic        m_end_reg, m_end_next;
    logic        m_valid_reg, m_valid_next;

    // Stack of pending ranges, held as registers.
    logic [IDX_W-1:0] stk_lo [CAPACITY];
    logic [IDX_W-1:0] stk_hi [CAPACITY];

    // Stack write requests, up to two per cycle.
    logic             push0_en, push1_en;
    logic [IDX_W-1:0] push0_idx, push1_idx;
    logic [IDX_W-1:0] push0_lo, push0_hi, push1_lo, push1_hi;

    // RAM interface.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr_a, ram_raddr_b;
    logic [63:0]      ram_rdata_a, ram_rdata_b;

    // Helpers.
    logic             s_accept;
    logic             store_room;
    logic [CNT_W-1:0] count_after;
    logic [IDX_W-1:0] pop_idx;
    logic             le_pivot;
    logic             bnd_is_cursor;
    logic             cursor_at_hi;
    logic [CNT_W:0]   lo_wide, hi_wide, bnd_wide;
    logic             left_push, right_push;
    logic [CNT_W-1:0] top_after_left;

    qls_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (ram_raddr_a),
        .rd_data_a (ram_rdata_a),
        .rd_addr_b (ram_raddr_b),
        .rd_data_b (ram_rdata_b)
    );

    assign s_ready        = (state_reg == ST_LOAD);
    assign s_accept       = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_end_of_set   = m_end_reg;

    // Items beyond the store capacity are dropped.
    assign store_room  = (count_reg < CAP_CNT);
    assign count_after = store_room ? count_reg + CNT_W'(1) : count_reg;

    assign pop_idx = IDX_W'(top_reg - CNT_W'(1));

    // The single shared comparator: scanned element against the pivot.
    assign le_pivot      = ($signed(ram_rdata_a) <= $signed(pivot_reg));
    assign bnd_is_cursor = (bnd_reg == CNT_W'(cursor_reg));
    assign cursor_at_hi  = (cursor_reg == hi_reg);

    // The pivot lands at bnd - 1. The left range [lo, bnd-2] exists when bnd > lo + 2,
    // the right range [bnd, hi] when bnd < hi.
    assign lo_wide        = (CNT_W + 1)'(lo_reg);
    assign hi_wide        = (CNT_W + 1)'(hi_reg);
    assign bnd_wide       = (CNT_W + 1)'(bnd_reg);
    assign left_push      = (bnd_wide > lo_wide + (CNT_W + 1)'(2)) && (top_reg < CAP_CNT);
    assign top_after_left = left_push ? top_reg + CNT_W'(1) : top_reg;
    assign right_push     = (bnd_wide < hi_wide) && (top_after_left < CAP_CNT);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cursor_next  = cursor_reg;
        bnd_next     = bnd_reg;
        out_idx_next = out_idx_reg;
        pivot_next   = pivot_reg;
        swap_next    = swap_reg;
        m_value_next = m_value_reg;
        m_end_next   = m_end_reg;
        m_valid_next = m_valid_reg;

        push0_en  = 1'b0;
        push0_idx = top_reg[IDX_W-1:0];
        push0_lo  = lo_reg;
        push0_hi  = IDX_W'(bnd_reg - CNT_W'(2));
        push1_en  = 1'b0;
        push1_idx = top_after_left[IDX_W-1:0];
        push1_lo  = bnd_reg[IDX_W-1:0];
        push1_hi  = hi_reg;

        ram_we      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_wdata   = s_value;
        ram_raddr_a = cursor_reg;
        ram_raddr_b = bnd_reg[IDX_W-1:0];

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    ram_we     = store_room;
                    count_next = count_after;
                    if (s_is_last) begin
                        out_idx_next = '0;
                        if (count_after > CNT_W'(1)) begin
                            // Whole set is the first pending range.
                            push0_en   = 1'b1;
                            push0_idx  = '0;
                            push0_lo   = '0;
                            push0_hi   = IDX_W'(count_after - CNT_W'(1));
                            top_next   = CNT_W'(1);
                            state_next = ST_POP;
                        end else begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_POP: begin
                if (top_reg == '0) begin
                    state_next = ST_OUT_RD;
                end else begin
                    top_next    = top_reg - CNT_W'(1);
                    lo_next     = stk_lo[pop_idx];
                    hi_next     = stk_hi[pop_idx];
                    cursor_next = stk_lo[pop_idx];
                    bnd_next    = CNT_W'(stk_lo[pop_idx]);
                    ram_raddr_a = stk_hi[pop_idx];
                    state_next  = ST_PIVOT;
                end
            end
            ST_PIVOT: begin
                // Pivot read issued in the previous cycle; start the scan.
                pivot_next = ram_rdata_a;
                state_next = ST_CMP;
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (le_pivot) begin
                    bnd_next = bnd_reg + CNT_W'(1);
                end
                if (le_pivot && !bnd_is_cursor) begin
                    // First half of the exchange: boundary slot takes the scanned element.
                    ram_we     = 1'b1;
                    ram_waddr  = bnd_reg[IDX_W-1:0];
                    ram_wdata  = ram_rdata_a;
                    swap_next  = ram_rdata_b;
                    state_next = ST_SWAP;
                end else if (cursor_at_hi) begin
                    state_next = ST_PUSH;
                end else begin
                    cursor_next = cursor_reg + IDX_W'(1);
                    state_next  = ST_READ;
                end
            end
            ST_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = cursor_reg;
                ram_wdata = swap_reg;
                if (cursor_at_hi) begin
                    state_next = ST_PUSH;
                end else begin
                    cursor_next = cursor_reg + IDX_W'(1);
                    state_next  = ST_READ;
                end
            end
            ST_PUSH: begin
                push0_en   = left_push;
                push1_en   = right_push;
                top_next   = right_push ? top_after_left + CNT_W'(1) : top_after_left;
                state_next = ST_POP;
            end
            ST_OUT_RD: begin
                ram_raddr_a = out_idx_reg;
                state_next  = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                m_value_next = ram_rdata_a;
                m_end_next   = (CNT_W'(out_idx_reg) + CNT_W'(1) == count_reg);
                m_valid_next = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_end_reg) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        out_idx_next = out_idx_reg + IDX_W'(1);
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            top_reg     <= '0;
            cursor_reg  <= '0;
            bnd_reg     <= '0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            top_reg     <= top_next;
            cursor_reg  <= cursor_next;
            bnd_reg     <= bnd_next;
            out_idx_reg <= out_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pivot_reg   <= pivot_next;
        swap_reg    <= swap_next;
        m_value_reg <= m_value_next;
        m_end_reg   <= m_end_next;
    end

    // Range stack writes; the two pushes always target different entries.
    always_ff @(posedge aclk) begin
        if (push0_en) begin
            stk_lo[push0_idx] <= push0_lo;
            stk_hi[push0_idx] <= push0_hi;
        end
        if (push1_en) begin
            stk_lo[push1_idx] <= push1_lo;
            stk_hi[push1_idx] <= push1_hi;
        end
    end

endmodule

@@ sv/qls_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module qls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ verif/quicksort_lomuto_sorter_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quicksort sorter result checker
// Watches both channels of the sorter, keeps its own copy of the set being
// loaded, orders it when the closing item arrives, and compares every result
// against the ascending order it expects.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter_unit_checker #(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [63:0] s_value,
    input  logic               s_is_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [63:0] m_sorted_value,
    input  logic               m_end_of_set,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct packed {
        logic signed [63:0] value;
        logic               last;
    } sorted_entry_t;

    // Values of the set being loaded; items past the capacity are dropped.
    logic signed [63:0] load_buf [CAPACITY];
    int                 load_count;
    // Results owed by the sorter, oldest first.
    sorted_entry_t      sorted_due [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
        load_count  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin : watch
        logic signed [63:0] key;
        int                 j;
        sorted_entry_t      due;
        if (!aresetn) begin
            sorted_due.delete();
            load_count = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              m_sorted_value));
                end else begin
                    due = sorted_due.pop_front();
                    if (m_sorted_value !== due.value) begin
                        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                                  m_sorted_value, due.value));
                    end
                    if (m_end_of_set !== due.last) begin
                        report_mismatch($sformatf("end_of_set %b, expected %b on value %0d",
                                                  m_end_of_set, due.last, due.value));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (load_count < CAPACITY) begin
                    load_buf[load_count] = s_value;
                    load_count++;
                end
                if (s_is_last) begin
                    // Signed ascending order; ties are indistinguishable at the output.
                    for (int i = 1; i < load_count; i++) begin
                        key = load_buf[i];
                        j   = i - 1;
                        while (j >= 0 && load_buf[j] > key) begin
                            load_buf[j + 1] = load_buf[j];
                            j--;
                        end
                        load_buf[j + 1] = key;
                    end
                    for (int i = 0; i < load_count; i++) begin
                        due.value = load_buf[i];
                        due.last  = (i == load_count - 1);
                        sorted_due.push_back(due);
                    end
                    load_count = 0;
                end
            end
            outstanding <= sorted_due.size();
        end
    end

endmodule

@@ verif/quicksort_lomuto_sorter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quicksort sorter testbench
// Feeds sets of signed 64-bit items to the sorter, from single items up to
// sets that overflow the store, with random idling on both channels. The
// checker beside the block predicts and compares; this module only makes the
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter_unit_tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 290;
    // The last stretch of items runs with no idling on either side.
    localparam int CALM_ITEMS   = 30;

    localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // How the values of one random set are drawn.
    typedef enum int {
        FILL_RANDOM,
        FILL_CLUSTER,
        FILL_EXTREME,
        FILL_RISING,
        FILL_FALLING
    } fill_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic signed [63:0] s_value   = '0;
    logic               s_is_last = 1'b0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [63:0] m_sorted_value;
    logic               m_end_of_set;

    int fail_count;
    int outstanding;

    // When quiet is set, neither side idles; idle_on turns sender gaps on per set.
    bit quiet   = 1'b0;
    bit idle_on = 1'b1;

    // The clock runs with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    quicksort_lomuto_sorter_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_end_of_set  (m_end_of_set)
    );

    quicksort_lomuto_sorter_unit_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_end_of_set  (m_end_of_set),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Presents one item and returns at the edge where it is accepted. A random
    // idle burst may come first; valid is lowered only at the start of a burst,
    // so it never drops and rises within the same time step.
    task automatic send_item(input logic signed [63:0] value, input bit last);
        if (!quiet && idle_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_value   <= value;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drops valid and holds the sender off until every owed result has come back.
    // The first edge lets the checker take in the item that was just accepted.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Draws the value at position pos of a random set.
    function automatic logic signed [63:0] pick_value(input fill_t fill, input int pos,
                                                      input logic signed [63:0] base);
        case (fill)
            FILL_RANDOM: begin
                return {$urandom, $urandom};
            end
            FILL_CLUSTER: begin
                // A narrow spread around the base gives many equal values.
                return base + 64'($urandom_range(0, 3));
            end
            FILL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 64'sd0;
                    3:       return -64'sd1;
                    default: return VAL_MIN + 64'sd1;
                endcase
            end
            FILL_RISING: begin
                return base + 64'(pos);
            end
            default: begin
                return base - 64'(pos);
            end
        endcase
    endfunction

    // The result side stalls in random bursts and otherwise takes results for
    // a random stretch, sometimes a long one. Each edge gets a single update.
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(40, 120)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Stimulus: a directed part covering the edge cases, then random sets.
    initial begin
        int                 items_sent;
        int                 set_size;
        fill_t              fill;
        logic signed [63:0] base;

        items_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A set of one item: it is its own largest element and closes the set.
        send_item(VAL_MAX, 1'b1);
        // Two items at the extremes, given in reverse order.
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);
        // Equal values around zero.
        send_item(64'sd0, 1'b0);
        send_item(-64'sd1, 1'b0);
        send_item(64'sd1, 1'b0);
        send_item(-64'sd1, 1'b1);
        // A full store in descending order, the worst case for this pivot choice,
        // then a closing item that finds the store full: it is dropped, yet the
        // sort and the output of the stored items still happen.
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0) begin
                send_item(VAL_MAX, 1'b0);
            end else if (i == CAPACITY - 1) begin
                send_item(VAL_MIN, 1'b0);
            end else begin
                send_item(64'sd1000 - 64'(i) * 64'sd77, 1'b0);
            end
        end
        send_item(64'sh5555_5555_5555_5555, 1'b1);

        // Hold the sender back once until the whole directed output is through.
        wait_drained();

        // Random sets, mostly of ordinary size, some full, some overflowing.
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
                1:       set_size = CAPACITY;
                2:       set_size = $urandom_range(1, 3);
                default: set_size = $urandom_range(2, 12);
            endcase
            fill    = fill_t'($urandom_range(0, 4));
            base    = {$urandom, $urandom};
            idle_on = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < set_size; k++) begin
                quiet = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
                send_item(pick_value(fill, k, base), k == set_size - 1);
                // Items that overflow the store are ignored by the block.
                if (k < CAPACITY) begin
                    items_sent++;
                end
            end
            if (!quiet && $urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end

        // Drain the last set and allow a short tail for any stray result.
        wait_drained();
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
